>>> design/mann_whitney_exact_cdf_assert.svh
// ----------------------------------------------------------------------------
// mann_whitney_exact_cdf_assert.svh
// assertion macros shared by the rank-sum distribution block
// ----------------------------------------------------------------------------
`ifndef MANN_WHITNEY_EXACT_CDF_ASSERT_SVH
`define MANN_WHITNEY_EXACT_CDF_ASSERT_SVH

// same-cycle implication, checked outside reset
`define MWU_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define MWU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/mwu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwu_pkg
// shared widths, defaults and interface types of the rank-sum distribution block
// ----------------------------------------------------------------------------
package mwu_pkg;

    // field widths
    localparam int RANK_W  = 10;
    localparam int SIZE_W  = 5;
    localparam int COUNT_W = 30;
    localparam int PROB_W  = 32;

    // default sizing
    localparam int DEF_MAX_SAMPLE  = 16;
    localparam int DEF_TABLE_DEPTH = 257;

    // job handed to the table builder
    typedef struct packed {
        logic [SIZE_W-1:0] lo_size;
        logic [SIZE_W-1:0] hi_size;
        logic [RANK_W-1:0] u;
    } job_t;

    // status returned by the table builder
    typedef struct packed {
        logic               done;
        logic [COUNT_W-1:0] tail;
        logic [COUNT_W-1:0] total;
    } table_res_t;

endpackage

>>> design/mwu_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwu_ram
// generic single-write, dual-read synchronous ram with registered read data
// ----------------------------------------------------------------------------
module mwu_ram #(
    parameter int WIDTH = mwu_pkg::COUNT_W,
    parameter int DEPTH = mwu_pkg::DEF_TABLE_DEPTH
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr0,
    input  logic [$clog2(DEPTH)-1:0] raddr1,
    output logic [WIDTH-1:0]         rdata0,
    output logic [WIDTH-1:0]         rdata1
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write and registered reads; a read at the written address sees old data
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata0 <= mem[raddr0];
        rdata1 <= mem[raddr1];
    end

endmodule

>>> design/mwu_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwu_div
// restoring divider, one quotient bit per cycle, gives floor(num * 2^32 / den), all ones if num >= den
// ----------------------------------------------------------------------------
module mwu_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [mwu_pkg::COUNT_W-1:0]  num,
    input  logic [mwu_pkg::COUNT_W-1:0]  den,
    output logic                         done,
    output logic [mwu_pkg::PROB_W-1:0]   quot
);

    import mwu_pkg::*;

    localparam int CNT_W = $clog2(PROB_W);

    typedef enum logic [1:0] {D_IDLE, D_RUN, D_DONE} dstate_t;

    dstate_t            state_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [COUNT_W-1:0] rem_reg;
    logic [COUNT_W-1:0] den_reg;
    logic [PROB_W-1:0]  quo_reg;

    logic [COUNT_W:0]   rem_shift;
    logic               fits;
    logic [COUNT_W-1:0] rem_next;

    // one restoring step; remainder stays below the divisor
    always_comb
    begin
        rem_shift = {rem_reg, 1'b0};
        fits      = rem_shift >= (COUNT_W + 1)'(den_reg);
        rem_next  = fits ? COUNT_W'(rem_shift - (COUNT_W + 1)'(den_reg))
                         : rem_shift[COUNT_W-1:0];
    end

    // sequencer and datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            cnt_reg   <= '0;
            rem_reg   <= '0;
            den_reg   <= '0;
            quo_reg   <= '0;
        end
        else
        begin
            unique case (state_reg)
                D_IDLE:
                begin
                    if (start)
                    begin
                        den_reg <= den;
                        rem_reg <= num;
                        cnt_reg <= '0;
                        // quotient of one or more saturates
                        if (num >= den)
                        begin
                            quo_reg   <= '1;
                            state_reg <= D_DONE;
                        end
                        else
                        begin
                            quo_reg   <= '0;
                            state_reg <= D_RUN;
                        end
                    end
                end
                D_RUN:
                begin
                    rem_reg <= rem_next;
                    quo_reg <= {quo_reg[PROB_W-2:0], fits};
                    if (cnt_reg == CNT_W'(PROB_W - 1))
                    begin
                        state_reg <= D_DONE;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + CNT_W'(1);
                    end
                end
                D_DONE:
                begin
                    state_reg <= D_IDLE;
                end
                default:
                begin
                    state_reg <= D_IDLE;
                end
            endcase
        end
    end

    assign done = (state_reg == D_DONE);
    assign quot = quo_reg;

endmodule

>>> design/mwu_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwu_table
// builds the frequency table of U in the count memory and sums its tail and total
// ----------------------------------------------------------------------------
module mwu_table #(
    parameter int TABLE_DEPTH = mwu_pkg::DEF_TABLE_DEPTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  mwu_pkg::job_t       job,
    output mwu_pkg::table_res_t res
);

    import mwu_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int XW = (AW > RANK_W) ? AW : RANK_W;

    typedef enum logic [2:0] {
        T_IDLE, T_CLEAR, T_PREFIX, T_DIFF, T_SUM, T_DRAIN, T_DONE
    } tstate_t;

    typedef enum logic [1:0] {OP_ADD, OP_SUB, OP_SUM} op_t;

    tstate_t            state_reg;
    logic [AW-1:0]      j_reg;
    logic [AW-1:0]      deg_reg;
    logic [SIZE_W-1:0]  i_reg;
    logic [SIZE_W-1:0]  small_reg;
    logic [SIZE_W-1:0]  large_reg;
    logic [RANK_W-1:0]  u_reg;

    // read stage registers
    logic               p_valid_reg;
    op_t                p_op_reg;
    logic [AW-1:0]      p_addr0_reg;
    logic [AW-1:0]      p_addr1_reg;
    logic               p_tail_reg;

    // last write, for forwarding past the read latency
    logic               fwd_valid_reg;
    logic [AW-1:0]      fwd_addr_reg;
    logic [COUNT_W-1:0] fwd_data_reg;

    logic [COUNT_W-1:0] tail_reg;
    logic [COUNT_W-1:0] total_reg;

    logic [2*SIZE_W-1:0] deg_prod;
    logic [XW-1:0]       j_x;
    logic [XW-1:0]       i_x;
    logic [XW-1:0]       deg_x;
    logic [XW-1:0]       stride_x;
    logic [XW-1:0]       u_x;
    logic                last_i;
    logic                diff_used;

    logic               issue;
    op_t                iss_op;
    logic [AW-1:0]      raddr0;
    logic [AW-1:0]      raddr1;
    logic [COUNT_W-1:0] rdata0;
    logic [COUNT_W-1:0] rdata1;
    logic [COUNT_W-1:0] opa;
    logic [COUNT_W-1:0] opb;

    logic               we;
    logic [AW-1:0]      waddr;
    logic [COUNT_W-1:0] wdata;

    // table length and loop bounds
    assign deg_prod  = (2 * SIZE_W)'(job.lo_size) * (2 * SIZE_W)'(job.hi_size);
    assign j_x       = XW'(j_reg);
    assign i_x       = XW'(i_reg);
    assign deg_x     = XW'(deg_reg);
    assign u_x       = XW'(u_reg);
    assign stride_x  = XW'(large_reg) + XW'(i_reg);
    assign last_i    = (i_reg == small_reg);
    assign diff_used = (deg_x >= stride_x);

    // read issue
    always_comb
    begin
        issue  = 1'b0;
        iss_op = OP_SUM;
        raddr0 = j_reg;
        raddr1 = '0;
        unique case (state_reg)
            T_PREFIX:
            begin
                issue  = 1'b1;
                iss_op = OP_ADD;
                raddr1 = AW'(j_x - i_x);
            end
            T_DIFF:
            begin
                issue  = 1'b1;
                iss_op = OP_SUB;
                raddr1 = AW'(j_x - stride_x);
            end
            T_SUM:
            begin
                issue  = 1'b1;
                iss_op = OP_SUM;
            end
            default:
            begin
                issue = 1'b0;
            end
        endcase
    end

    // operands with forwarding of the write that raced the read
    assign opa = (fwd_valid_reg && fwd_addr_reg == p_addr0_reg) ? fwd_data_reg : rdata0;
    assign opb = (fwd_valid_reg && fwd_addr_reg == p_addr1_reg) ? fwd_data_reg : rdata1;

    // write port: clearing sweep or read-modify-write result
    always_comb
    begin
        we    = 1'b0;
        waddr = p_addr0_reg;
        wdata = opa + opb;
        if (state_reg == T_CLEAR)
        begin
            we    = 1'b1;
            waddr = j_reg;
            wdata = (j_reg == '0) ? COUNT_W'(1) : '0;
        end
        else if (p_valid_reg && p_op_reg != OP_SUM)
        begin
            we    = 1'b1;
            wdata = (p_op_reg == OP_ADD) ? opa + opb : opa - opb;
        end
    end

    mwu_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (TABLE_DEPTH)
    ) u_count_ram (
        .clk    (clk),
        .we     (we),
        .waddr  (waddr),
        .wdata  (wdata),
        .raddr0 (raddr0),
        .raddr1 (raddr1),
        .rdata0 (rdata0),
        .rdata1 (rdata1)
    );

    // pipeline control bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg   <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            p_valid_reg   <= issue;
            fwd_valid_reg <= we;
        end
    end

    // pipeline payload and sums
    always_ff @(posedge clk)
    begin
        p_op_reg     <= iss_op;
        p_addr0_reg  <= raddr0;
        p_addr1_reg  <= raddr1;
        p_tail_reg   <= (j_x <= u_x);
        fwd_addr_reg <= waddr;
        fwd_data_reg <= wdata;
        if (state_reg == T_IDLE && start)
        begin
            tail_reg  <= '0;
            total_reg <= '0;
        end
        else if (p_valid_reg && p_op_reg == OP_SUM)
        begin
            total_reg <= total_reg + opa;
            if (p_tail_reg)
            begin
                tail_reg <= tail_reg + opa;
            end
        end
    end

    // pass sequencer: clear, per factor prefix sum and difference, then sum
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= T_IDLE;
            j_reg     <= '0;
            deg_reg   <= '0;
            i_reg     <= '0;
            small_reg <= '0;
            large_reg <= '0;
            u_reg     <= '0;
        end
        else
        begin
            unique case (state_reg)
                T_IDLE:
                begin
                    if (start)
                    begin
                        small_reg <= job.lo_size;
                        large_reg <= job.hi_size;
                        u_reg     <= job.u;
                        deg_reg   <= AW'(deg_prod);
                        j_reg     <= '0;
                        state_reg <= T_CLEAR;
                    end
                end
                T_CLEAR:
                begin
                    if (j_reg == deg_reg)
                    begin
                        i_reg     <= SIZE_W'(1);
                        j_reg     <= AW'(1);
                        state_reg <= T_PREFIX;
                    end
                    else
                    begin
                        j_reg <= j_reg + AW'(1);
                    end
                end
                T_PREFIX:
                begin
                    if (j_reg == deg_reg)
                    begin
                        priority if (diff_used)
                        begin
                            state_reg <= T_DIFF;
                        end
                        else if (last_i)
                        begin
                            j_reg     <= '0;
                            state_reg <= T_SUM;
                        end
                        else
                        begin
                            i_reg <= i_reg + SIZE_W'(1);
                            j_reg <= AW'(i_x + XW'(1));
                        end
                    end
                    else
                    begin
                        j_reg <= j_reg + AW'(1);
                    end
                end
                T_DIFF:
                begin
                    if (j_x == stride_x)
                    begin
                        if (last_i)
                        begin
                            j_reg     <= '0;
                            state_reg <= T_SUM;
                        end
                        else
                        begin
                            i_reg     <= i_reg + SIZE_W'(1);
                            j_reg     <= AW'(i_x + XW'(1));
                            state_reg <= T_PREFIX;
                        end
                    end
                    else
                    begin
                        j_reg <= j_reg - AW'(1);
                    end
                end
                T_SUM:
                begin
                    if (j_reg == deg_reg)
                    begin
                        state_reg <= T_DRAIN;
                    end
                    else
                    begin
                        j_reg <= j_reg + AW'(1);
                    end
                end
                T_DRAIN:
                begin
                    state_reg <= T_DONE;
                end
                T_DONE:
                begin
                    state_reg <= T_IDLE;
                end
                default:
                begin
                    state_reg <= T_IDLE;
                end
            endcase
        end
    end

    assign res.done  = (state_reg == T_DONE);
    assign res.tail  = tail_reg;
    assign res.total = total_reg;

endmodule

>>> design/mann_whitney_exact_cdf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mann_whitney_exact_cdf
// exact lower-tail probability of the Wilcoxon rank-sum / Mann-Whitney U
// ----------------------------------------------------------------------------
// Takes one query at a time and returns one result item per query. A query
// with a zero or oversized sample, a size product that does not fit the
// table, or a rank sum below its minimum, comes back flagged invalid without
// a table pass, its result going through the done state into the output
// register. Otherwise, with s the smaller and L the larger size and D = s*L,
// the count table is swept entry by entry through a single write port of
// the count memory: a pass to clear it, for each factor i = 1..s a prefix-sum
// pass plus, where D >= L+i, a difference pass, a pass to sum it, then the
// bit-serial divide and a hand-over. The next query is taken as soon as the
// result has moved into the output register, even while that result is
// stalled.
module mann_whitney_exact_cdf #(
    parameter int MAX_SAMPLE  = mwu_pkg::DEF_MAX_SAMPLE,
    parameter int TABLE_DEPTH = mwu_pkg::DEF_TABLE_DEPTH
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [mwu_pkg::RANK_W-1:0]   rank_sum,
    input  logic [mwu_pkg::SIZE_W-1:0]   first_size,
    input  logic [mwu_pkg::SIZE_W-1:0]   second_size,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [mwu_pkg::COUNT_W-1:0]  tail_count,
    output logic [mwu_pkg::COUNT_W-1:0]  total_count,
    output logic [mwu_pkg::PROB_W-1:0]   probability,
    output logic                         invalid
);

    import mwu_pkg::*;

`include "mann_whitney_exact_cdf_assert.svh"

    typedef enum logic [1:0] {S_IDLE, S_TABLE, S_DIV, S_DONE} state_t;

    state_t             state_reg;
    logic               tbl_start_reg;
    logic               div_start_reg;
    job_t               job_reg;
    logic [COUNT_W-1:0] res_tail_reg;
    logic [COUNT_W-1:0] res_total_reg;
    logic [PROB_W-1:0]  res_prob_reg;
    logic               res_bad_reg;
    logic               out_valid_reg;
    logic [COUNT_W-1:0] out_tail_reg;
    logic [COUNT_W-1:0] out_total_reg;
    logic [PROB_W-1:0]  out_prob_reg;
    logic               out_bad_reg;

    logic [2*SIZE_W-1:0] size_prod;
    logic [2*SIZE_W-1:0] tri_full;
    logic [RANK_W-1:0]   rank_min;
    logic                bad_query;
    logic [SIZE_W-1:0]   small_size;
    logic [SIZE_W-1:0]   large_size;
    logic                in_take;
    logic                out_load;

    table_res_t         tbl_res;
    logic               div_done;
    logic [PROB_W-1:0]  div_quot;

    // query screening and U
    assign size_prod  = (2 * SIZE_W)'(first_size) * (2 * SIZE_W)'(second_size);
    assign tri_full   = (2 * SIZE_W)'(first_size) * ((2 * SIZE_W)'(first_size) + 1'b1);
    assign rank_min   = RANK_W'(tri_full >> 1);
    assign small_size = (first_size < second_size) ? first_size : second_size;
    assign large_size = (first_size < second_size) ? second_size : first_size;
    assign bad_query  = (first_size == '0) || (second_size == '0) ||
                        (first_size > SIZE_W'(MAX_SAMPLE)) ||
                        (second_size > SIZE_W'(MAX_SAMPLE)) ||
                        (size_prod >= (2 * SIZE_W)'(TABLE_DEPTH)) ||
                        (rank_sum < rank_min);

    assign in_stall = (state_reg != S_IDLE);
    assign in_take  = in_valid && !in_stall;
    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);

    mwu_table #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .rst_n (rst_n),
        .start (tbl_start_reg),
        .job   (job_reg),
        .res   (tbl_res)
    );

    mwu_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start_reg),
        .num   (res_tail_reg),
        .den   (res_total_reg),
        .done  (div_done),
        .quot  (div_quot)
    );

    // query sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            tbl_start_reg <= 1'b0;
            div_start_reg <= 1'b0;
            job_reg       <= '0;
            res_tail_reg  <= '0;
            res_total_reg <= '0;
            res_prob_reg  <= '0;
            res_bad_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            out_tail_reg  <= '0;
            out_total_reg <= '0;
            out_prob_reg  <= '0;
            out_bad_reg   <= 1'b0;
        end
        else
        begin
            tbl_start_reg <= 1'b0;
            div_start_reg <= 1'b0;
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_take)
                    begin
                        res_bad_reg <= bad_query;
                        if (bad_query)
                        begin
                            res_tail_reg  <= '0;
                            res_total_reg <= '0;
                            res_prob_reg  <= '0;
                            state_reg     <= S_DONE;
                        end
                        else
                        begin
                            job_reg.lo_size <= small_size;
                            job_reg.hi_size <= large_size;
                            job_reg.u       <= rank_sum - rank_min;
                            tbl_start_reg   <= 1'b1;
                            state_reg       <= S_TABLE;
                        end
                    end
                end
                S_TABLE:
                begin
                    if (tbl_res.done)
                    begin
                        res_tail_reg  <= tbl_res.tail;
                        res_total_reg <= tbl_res.total;
                        div_start_reg <= 1'b1;
                        state_reg     <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        res_prob_reg <= div_quot;
                        state_reg    <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (out_load)
                    begin
                        out_valid_reg <= 1'b1;
                        out_tail_reg  <= res_tail_reg;
                        out_total_reg <= res_total_reg;
                        out_prob_reg  <= res_prob_reg;
                        out_bad_reg   <= res_bad_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid   = out_valid_reg;
    assign tail_count  = out_tail_reg;
    assign total_count = out_total_reg;
    assign probability = out_prob_reg;
    assign invalid     = out_bad_reg;

    // checks
    `MWU_ASSERT_NEXT(a_busy_after_take, clk, rst_n, in_take, in_stall,
                     "query taken but input not stalled next cycle")
    `MWU_ASSERT_NOW(a_table_done_in_table, clk, rst_n, tbl_res.done,
                    state_reg == S_TABLE, "table finished outside table phase")
    `MWU_ASSERT_NOW(a_invalid_zero, clk, rst_n, out_valid && invalid,
                    tail_count == '0 && total_count == '0 && probability == '0,
                    "invalid result carries non-zero counts")
    `MWU_ASSERT_NOW(a_tail_bounded, clk, rst_n, out_valid && !invalid,
                    total_count != '0 && tail_count <= total_count,
                    "tail count exceeds total count")

endmodule
